@@ rtl/core/slc_pkg.sv @@
`timescale 1ns / 1ps

package slc_pkg;

   // Operation codes carried on the request channel
   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // Framing constants
   localparam logic [7:0] SYNC_FIRST   = 8'h2D;
   localparam logic [7:0] SYNC_SECOND  = 8'hD4;
   localparam logic [7:0] SUM_SEED     = 8'h01;
   localparam logic [7:0] HUNT_RESTART = 8'd255;
   localparam logic [15:0] ERROR_MAX   = 16'hFFFF;

   // Event codes reported with each response
   typedef enum logic [2:0] {
      EVENT_NONE      = 3'd0,
      EVENT_ACCEPT    = 3'd1,
      EVENT_BAD_SYNC  = 3'd2,
      EVENT_BAD_SUM   = 3'd3,
      EVENT_DROPPED   = 3'd4,
      EVENT_SATURATED = 3'd5
   } event_type;

   // One request transaction
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic [6:0] read_index;
   } req_item_type;

   // Per-transaction status handed from the deframer to the response pipeline
   typedef struct packed {
      event_type   event_res;
      logic        read_ok;
      logic [7:0]  head_length;
      logic [3:0]  message_count;
      logic [15:0] error_count;
   } stage_type;

endpackage

@@ rtl/core/slc_channels.sv @@
`timescale 1ns / 1ps

// Request channel: received byte, head read or head release
interface slc_req_if ();
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] rx_byte;
   logic [6:0] read_index;

   modport source (output valid, op, rx_byte, read_index, input ready);
   modport sink (input valid, op, rx_byte, read_index, output ready);
endinterface

// Response channel: event and status, one per request
interface slc_rsp_if ();
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  read_data;
   logic [7:0]  head_length;
   logic [3:0]  message_count;
   logic [15:0] error_count;

   modport source (output valid, event_res, read_data, head_length, message_count,
                   error_count, input ready);
   modport sink (input valid, event_res, read_data, head_length, message_count,
                 error_count, output ready);
endinterface

@@ rtl/core/slc_ram.sv @@
`timescale 1ns / 1ps

module slc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/slc_deframe.sv @@
`timescale 1ns / 1ps

module slc_deframe #(
   parameter int FIFO_DEPTH    = 8,
   parameter int PAYLOAD_BYTES = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  slc_pkg::req_item_type item,
   output slc_pkg::stage_type    info,
   output logic [7:0]           rd_data
);

   localparam int SLOT_W = $clog2(FIFO_DEPTH);
   localparam int IDX_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int ADDR_W = SLOT_W + IDX_W;
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

   logic [7:0]        pos_ff, pos_in, pos_tmp;
   logic [7:0]        end_ff, end_in;
   logic [7:0]        sum_ff, sum_in;
   logic [SLOT_W-1:0] ws_ff, ws_in;
   logic [SLOT_W-1:0] rs_ff, rs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]       err_ff, err_in;
   logic [7:0]        len_ff [FIFO_DEPTH];

   logic                 bump;
   slc_pkg::event_type   ev;
   logic                 len_we;
   logic [7:0]           len_wdata;
   logic                 pay_we;
   logic [7:0]           pay_idx;
   logic [7:0]           read_idx;
   logic                 rd_en;
   logic                 read_ok;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ADDR_W-1:0]    rd_addr;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
      return (s == '0) ? SLOT_W'(FIFO_DEPTH - 1) : s - 1'b1;
   endfunction

   assign pay_idx   = pos_ff - 8'd3;
   assign read_idx  = {1'b0, item.read_index};
   assign len_wdata = item.rx_byte - 8'd1;

   // Decode the transaction and compute the next framing and ring state
   always_comb begin
      pos_tmp = pos_ff;
      pos_in  = pos_ff;
      end_in  = end_ff;
      sum_in  = sum_ff;
      ws_in   = ws_ff;
      rs_in   = rs_ff;
      cnt_in  = cnt_ff;
      bump    = 1'b0;
      ev      = slc_pkg::EVENT_NONE;
      len_we  = 1'b0;
      pay_we  = 1'b0;
      rd_en   = 1'b0;
      read_ok = 1'b0;
      if (accept) begin
         case (item.op)
            slc_pkg::OP_BYTE: begin
               if (pos_ff == 8'd0) begin
                  if (item.rx_byte != slc_pkg::SYNC_FIRST) begin
                     pos_tmp = slc_pkg::HUNT_RESTART;
                     bump    = 1'b1;
                     ev      = slc_pkg::EVENT_BAD_SYNC;
                  end
               end else if (pos_ff == 8'd1) begin
                  if (item.rx_byte != slc_pkg::SYNC_SECOND) begin
                     pos_tmp = slc_pkg::HUNT_RESTART;
                     bump    = 1'b1;
                     ev      = slc_pkg::EVENT_BAD_SYNC;
                  end
               end else if (pos_ff == 8'd2) begin
                  // Length byte: claim a slot, drop the oldest if it is taken
                  end_in = item.rx_byte + 8'd2;
                  sum_in = item.rx_byte + slc_pkg::SUM_SEED;
                  ws_in  = next_slot(ws_ff);
                  len_we = 1'b1;
                  if (ws_in == rs_ff && cnt_ff != '0) begin
                     rs_in = next_slot(rs_ff);
                     bump  = 1'b1;
                     ev    = slc_pkg::EVENT_DROPPED;
                  end
               end else if (pos_ff == end_ff) begin
                  // Checksum byte: commit, flag saturation when full, or give the slot back
                  pos_tmp = slc_pkg::HUNT_RESTART;
                  if (item.rx_byte == sum_ff) begin
                     if (cnt_ff == CNT_W'(FIFO_DEPTH)) begin
                        bump = 1'b1;
                        ev   = slc_pkg::EVENT_SATURATED;
                     end else begin
                        cnt_in = cnt_ff + 1'b1;
                        ev     = slc_pkg::EVENT_ACCEPT;
                     end
                  end else begin
                     bump  = 1'b1;
                     ev    = slc_pkg::EVENT_BAD_SUM;
                     ws_in = prev_slot(ws_ff);
                  end
               end else begin
                  // Payload byte: sum always, store only inside the slot
                  pay_we = (pay_idx < 8'(PAYLOAD_BYTES));
                  sum_in = sum_ff + item.rx_byte;
               end
               pos_in = pos_tmp + 8'd1;
            end
            slc_pkg::OP_READ: begin
               rd_en   = 1'b1;
               read_ok = (cnt_ff != '0) && (read_idx < 8'(PAYLOAD_BYTES));
            end
            slc_pkg::OP_RELEASE: begin
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - 1'b1;
                  rs_in  = next_slot(rs_ff);
               end
            end
            default: begin
            end
         endcase
      end
      err_in = (bump && err_ff != slc_pkg::ERROR_MAX) ? err_ff + 16'd1 : err_ff;
   end

   // Hold framing and ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         end_ff <= '0;
         sum_ff <= '0;
         ws_ff  <= SLOT_W'(FIFO_DEPTH - 1);
         rs_ff  <= '0;
         cnt_ff <= '0;
         err_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         end_ff <= end_in;
         sum_ff <= sum_in;
         ws_ff  <= ws_in;
         rs_ff  <= rs_in;
         cnt_ff <= cnt_in;
         err_ff <= err_in;
      end
   end

   // Store slot lengths
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_ff[ws_in] <= len_wdata;
      end
   end

   // Payload store, one slot of 2**IDX_W bytes per ring entry
   assign wr_addr = {ws_ff, pay_idx[IDX_W-1:0]};
   assign rd_addr = {rs_ff, read_idx[IDX_W-1:0]};

   slc_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH * (2 ** IDX_W))
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (wr_addr),
      .wr_data (item.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status after this transaction's update
   always_comb begin
      info.event_res     = ev;
      info.read_ok       = read_ok;
      info.head_length   = (len_we && ws_in == rs_in) ? len_wdata : len_ff[rs_in];
      info.message_count = 4'(cnt_in);
      info.error_count   = err_in;
   end

endmodule

@@ rtl/core/sync_length_checksum_deframer.sv @@
// A response is registered in the status stage, then in the response register.
// Throughput: one transaction per cycle unless the response stalls; the
// state update is a single pass between the request edge and the status
// register, the head read is the payload RAM's registered read port.
// Reset (synchronous, active high) resets framing, ring pointers and counters;
// slot lengths and payload bytes are not cleared.
`timescale 1ns / 1ps

module sync_length_checksum_deframer #(
   parameter int FIFO_DEPTH    = 8,
   parameter int PAYLOAD_BYTES = 128
) (
   input logic         clock,
   input logic         reset,
   slc_req_if.sink     req_ch,
   slc_rsp_if.source   rsp_ch
);

   logic                  req_accept;
   logic                  s1_adv;
   logic                  s1_valid_ff, s1_valid_in;
   slc_pkg::stage_type    s1_info_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   slc_pkg::stage_type    rsp_info_ff;
   logic [7:0]            rsp_data_ff;
   slc_pkg::req_item_type item;
   slc_pkg::stage_type    info;
   logic [7:0]            ram_q;

   // Handshake: the status stage moves on whenever the response register frees
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign item.op         = req_ch.op;
   assign item.rx_byte    = req_ch.rx_byte;
   assign item.read_index = req_ch.read_index;

   slc_deframe #(
      .FIFO_DEPTH    (FIFO_DEPTH),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_deframe (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .item    (item),
      .info    (info),
      .rd_data (ram_q)
   );

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // Track stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture status on accept, advance it with the RAM data into the response
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_info_ff <= info;
      end
      if (s1_adv) begin
         rsp_info_ff <= s1_info_ff;
         rsp_data_ff <= s1_info_ff.read_ok ? ram_q : 8'd0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.event_res     = rsp_info_ff.event_res;
   assign rsp_ch.read_data     = rsp_data_ff;
   assign rsp_ch.head_length   = rsp_info_ff.head_length;
   assign rsp_ch.message_count = rsp_info_ff.message_count;
   assign rsp_ch.error_count   = rsp_info_ff.error_count;

   // A full status stage behind a stalled response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while pipeline is blocked");

   // Every taken request occupies the status stage on the next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted transaction lost");

   // An accepted frame always leaves at least one message waiting
   a_accept_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.event_res == slc_pkg::EVENT_ACCEPT)
      |-> (rsp_ch.message_count != 4'd0))
      else $error("frame accepted with empty message count");

endmodule
